// File: rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] PAD_CODE = 8'h3D;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LENGTH   = 2'd1,
		ST_BAD_CHAR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CLS_ALPHA = 2'd0,
		CLS_PAD   = 2'd1,
		CLS_BAD   = 2'd2
	} char_kind_t;

	typedef struct packed {
		char_kind_t kind;
		logic [5:0] sextet;
	} char_class_t;

	// results caused by one request, held until the output side takes them
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  n_bytes;
		logic        has_status;
		status_t     st;
	} b64d_bundle_t;

	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t c;
		c.kind   = CLS_BAD;
		c.sextet = 6'd0;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			c.kind   = CLS_ALPHA;
			c.sextet = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			c.kind   = CLS_ALPHA;
			c.sextet = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			c.kind   = CLS_ALPHA;
			c.sextet = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == 8'h2B) begin
			c.kind   = CLS_ALPHA;
			c.sextet = 6'd62;
		end else if (ch == 8'h2F) begin
			c.kind   = CLS_ALPHA;
			c.sextet = 6'd63;
		end else if (ch == PAD_CODE) begin
			c.kind   = CLS_PAD;
		end
		return c;
	endfunction

endpackage

// File: rtl/core/b64d_quad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_quad
// Quad assembly state and per-character decode into a result bundle.
// ----------------------------------------------------------------------------
module b64d_quad
	import b64d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   char_code,
	input  logic         last_char,
	output b64d_bundle_t bundle
);

	logic [1:0]  pos_q;
	logic [17:0] buf_q;
	logic [1:0]  pad_q;
	logic        err_q;

	logic [1:0]  pos_n;
	logic [17:0] buf_n;
	logic [1:0]  pad_n;
	logic        err_n;
	char_class_t cls;
	logic [5:0]  val;

	always_comb begin
		cls    = classify(char_code);
		val    = 6'd0;
		err_n  = err_q;
		pad_n  = pad_q;
		pos_n  = pos_q;
		buf_n  = buf_q;
		bundle = '0;
		bundle.word = {buf_q, 6'd0};

		case (cls.kind)
			CLS_ALPHA: begin
				// data after padding in the same quad
				if (pad_q != 2'd0)
					err_n = 1'b1;
				val = cls.sextet;
			end
			CLS_PAD: begin
				if (pos_q < 2'd2)
					err_n = 1'b1;
				else
					pad_n = pad_q + 2'd1;
			end
			default: err_n = 1'b1;
		endcase

		bundle.word = {buf_q, val};
		if (pos_q == 2'd3) begin
			// padded quad is only legal at the end of the message
			if (pad_n != 2'd0 && !last_char)
				err_n = 1'b1;
			if (!err_n)
				bundle.n_bytes = (pad_n >= 2'd2) ? 2'd1 : 2'd3 - pad_n;
			pos_n = 2'd0;
			buf_n = '0;
			pad_n = 2'd0;
		end else begin
			pos_n = pos_q + 2'd1;
			buf_n = {buf_q[11:0], val};
		end

		if (last_char) begin
			bundle.has_status = 1'b1;
			if (pos_q != 2'd3)
				bundle.st = ST_LENGTH;
			else if (err_n)
				bundle.st = ST_BAD_CHAR;
			else
				bundle.st = ST_OK;
			pos_n = 2'd0;
			buf_n = '0;
			pad_n = 2'd0;
			err_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			buf_q <= '0;
			pad_q <= 2'd0;
			err_q <= 1'b0;
		end else if (take) begin
			pos_q <= pos_n;
			buf_q <= buf_n;
			pad_q <= pad_n;
			err_q <= err_n;
		end
	end

endmodule

// File: rtl/core/b64d_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_emit
// Result register that plays a bundle out one item per accepted cycle.
// ----------------------------------------------------------------------------
module b64d_emit
	import b64d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  b64d_bundle_t bundle,
	output logic         space,
	output logic         res_valid,
	input  logic         res_ready,
	output logic [7:0]   byte_value,
	output logic         is_status,
	output logic [1:0]   status,
	output logic         run_last
);

	b64d_bundle_t bundle_s1;
	logic         valid_s1;
	logic [1:0]   idx_q;

	logic         has_results;
	logic         load;
	logic [2:0]   total_m1;
	logic         is_final;
	logic         drain_last;
	logic         is_byte;

	assign has_results = (bundle.n_bytes != 2'd0) || bundle.has_status;
	assign load        = push && has_results;

	// item count is 1..4, so count minus one fits in two bits
	assign total_m1   = {1'b0, bundle_s1.n_bytes} + {2'b00, bundle_s1.has_status} - 3'd1;
	assign is_final   = (idx_q == total_m1[1:0]);
	assign drain_last = valid_s1 && res_ready && is_final;
	assign space      = !valid_s1 || drain_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (drain_last) begin
			valid_s1 <= 1'b0;
		end else if (valid_s1 && res_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			bundle_s1 <= bundle;
	end

	assign is_byte = (idx_q < bundle_s1.n_bytes);

	always_comb begin
		byte_value = 8'd0;
		if (is_byte) begin
			case (idx_q)
				2'd0:    byte_value = bundle_s1.word[23:16];
				2'd1:    byte_value = bundle_s1.word[15:8];
				2'd2:    byte_value = bundle_s1.word[7:0];
				default: byte_value = 8'd0;
			endcase
		end
	end

	assign res_valid = valid_s1;
	assign is_status = !is_byte;
	assign status    = is_byte ? ST_OK : bundle_s1.st;
	assign run_last  = is_final;

endmodule

// File: rtl/core/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder: one character per request in, decoded bytes and
// an end-of-message status out.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  char     | char_valid/char_ready  | char_code[7:0], last_char
//  res      | res_valid/res_ready    | byte_value[7:0], is_status,
//           |                        | status[1:0], run_last
//
// a character is decoded in the cycle it is accepted; its results (0 to 4
// items) appear from the result register on the next cycle
// the result register drains one item per cycle while res_ready is high
// input is held off while results are pending, up to the cycle their last
// item drains
// reset clears the quad state and the result register's valid flag; no sweep is needed
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] byte_value,
	output logic       is_status,
	output logic [1:0] status,
	output logic       run_last
);

	b64d_bundle_t bundle;
	logic         take;
	logic         space;

	assign char_ready = space;
	assign take       = char_valid && space;

	b64d_quad u_quad (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (char_code),
		.last_char (last_char),
		.bundle    (bundle)
	);

	b64d_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.bundle     (bundle),
		.space      (space),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.byte_value (byte_value),
		.is_status  (is_status),
		.status     (status),
		.run_last   (run_last)
	);

endmodule
